// File: src/pwp_pkg.sv
// Package for the pattern window player: shared codes, widths and reset values.
// No dependencies; used by pwp_pattern_mem and pattern_window_player_unit.
package pwp_pkg;

    // Pattern memory geometry
    localparam int PATTERN_DEPTH = 65536;
    localparam int ADDR_W        = $clog2(PATTERN_DEPTH);

    // Field widths
    localparam int PTR_W  = 17;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int NUM_CHAN = 5;

    // Input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_REST_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0] SAMPLE_PERIOD_RST  = 16'd1000;
    localparam logic [CNT_W-1:0] REST_PERIOD_RST    = 16'd15625;
    localparam logic [PTR_W-1:0] PATTERN_LENGTH_RST = 17'd65535;

    // Command characters and limits
    localparam logic [7:0] CMD_END    = 8'h2A;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [2:0] LAST_CHAN  = 3'd4;
    localparam logic [1:0] CMD_FULL   = 2'd3;
    localparam logic [PTR_W-1:0] PTR_RST = 17'd5;

    // Fetch sequencer: five reads, then one last capture
    localparam logic [2:0] FETCH_LAST = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FETCH
    } state_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: src/pwp_pattern_mem.sv
// Byte-wide pattern store: one write port, one registered read port.
// Depends on pwp_pkg for depth and address width.
module pwp_pattern_mem (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [pwp_pkg::ADDR_W-1:0] wr_addr,
    input  pwp_pkg::byte_t           wr_data,
    input  logic                     rd_en,
    input  logic [pwp_pkg::ADDR_W-1:0] rd_addr,
    output pwp_pkg::byte_t           rd_data
);

    pwp_pkg::byte_t mem [pwp_pkg::PATTERN_DEPTH];
    pwp_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/pattern_window_player_unit.sv
// Top level of the five-channel pattern window player.
// Depends on pwp_pkg and instantiates pwp_pattern_mem.
// Usage:
//   Command channel: drive func, rx_byte, write_address, write_data and raise
//   start; a word is taken at the rising edge where start is high and busy is
//   low. func selects a time tick, a received serial byte or a pattern write.
//   Result channel: done pulses for exactly one cycle, the cycle right after
//   the word was taken, with the channel bytes, rest_marker, echo_byte,
//   echo_valid, playing and windows_left valid in that cycle. The receiver
//   cannot stall; a result not taken in its cycle is gone.
//   Configuration: cfg_we writes register cfg_index from cfg_data; write only while idle.
// Busy:
//   A word that does not fire a sample leaves busy low, and a new word may
//   follow in the next cycle. A tick that fires a sample starts a fetch:
//   the five holding bytes are refilled from the pattern memory through its
//   registered read port, one read per cycle, and busy stays high for the
//   whole fetch.
// Reset:
//   rst_n clears all control state, the holding and output bytes and the
//   configuration registers to their defaults; the pattern memory is not cleared.
module pattern_window_player_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    // Command channel
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 func,
    input  logic [7:0]                 rx_byte,
    input  logic [15:0]                write_address,
    input  logic [7:0]                 write_data,
    // Configuration port
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [pwp_pkg::PTR_W-1:0]  cfg_data,
    // Result channel
    output logic                       done,
    output logic [7:0]                 chan_a,
    output logic [7:0]                 chan_c,
    output logic [7:0]                 chan_f,
    output logic [7:0]                 chan_k,
    output logic [7:0]                 chan_l,
    output logic                       rest_marker,
    output logic [7:0]                 echo_byte,
    output logic                       echo_valid,
    output logic                       playing,
    output logic [7:0]                 windows_left
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pwp_pkg::CNT_W-1:0] sample_period_reg;
    logic [pwp_pkg::CNT_W-1:0] rest_period_reg;
    logic [pwp_pkg::PTR_W-1:0] pattern_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg  <= pwp_pkg::SAMPLE_PERIOD_RST;
            rest_period_reg    <= pwp_pkg::REST_PERIOD_RST;
            pattern_length_reg <= pwp_pkg::PATTERN_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwp_pkg::CFG_SAMPLE_PERIOD:
                begin
                    sample_period_reg <= cfg_data[pwp_pkg::CNT_W-1:0];
                end
                pwp_pkg::CFG_REST_PERIOD:
                begin
                    rest_period_reg <= cfg_data[pwp_pkg::CNT_W-1:0];
                end
                pwp_pkg::CFG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= cfg_data;
                end
                default:
                begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Player state
    // ------------------------------------------------------------------
    pwp_pkg::state_t           state_reg, state_next;
    logic [2:0]                fetch_cnt_reg, fetch_cnt_next;
    logic [pwp_pkg::PTR_W-1:0] ptr_reg, ptr_next;
    pwp_pkg::byte_t            hold_reg [pwp_pkg::NUM_CHAN];
    pwp_pkg::byte_t            hold_next [pwp_pkg::NUM_CHAN];
    pwp_pkg::byte_t            out_reg [pwp_pkg::NUM_CHAN];
    pwp_pkg::byte_t            out_next [pwp_pkg::NUM_CHAN];
    logic                      marker_reg, marker_next;
    logic [pwp_pkg::CNT_W-1:0] sample_cnt_reg, sample_cnt_next;
    logic [pwp_pkg::CNT_W-1:0] rest_cnt_reg, rest_cnt_next;
    logic                      run_reg, run_next;
    logic                      resting_reg, resting_next;
    pwp_pkg::byte_t            win_reg, win_next;
    pwp_pkg::byte_t            cmd0_reg, cmd0_next;
    pwp_pkg::byte_t            cmd1_reg, cmd1_next;
    logic [1:0]                cmd_idx_reg, cmd_idx_next;
    logic                      done_reg;
    pwp_pkg::byte_t            echo_byte_reg;
    logic                      echo_valid_reg;

    // Sequencer controls
    logic           accept;
    logic           fire;
    logic           fetch_rd;
    logic           fetch_cap;
    pwp_pkg::byte_t rd_data;

    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Pattern memory: written by pattern writes, read by the fetch sweep.
    // Writes only happen in idle and reads only in fetch, so they never meet.
    // ------------------------------------------------------------------
    pwp_pattern_mem u_mem (
        .clk     (clk),
        .wr_en   (accept && (func == pwp_pkg::FUNC_WRITE)),
        .wr_addr (write_address[pwp_pkg::ADDR_W-1:0]),
        .wr_data (write_data),
        .rd_en   (fetch_rd),
        .rd_addr (ptr_reg[pwp_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Next state of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwp_pkg::ST_IDLE:
            begin
                if (accept && fire)
                begin
                    state_next = pwp_pkg::ST_FETCH;
                end
            end
            pwp_pkg::ST_FETCH:
            begin
                if (fetch_cnt_reg == pwp_pkg::FETCH_LAST)
                begin
                    state_next = pwp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: issue reads for the first five steps, capture one
    // step behind them.
    always_comb
    begin
        busy      = 1'b0;
        fetch_rd  = 1'b0;
        fetch_cap = 1'b0;
        case (state_reg)
            pwp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            pwp_pkg::ST_FETCH:
            begin
                busy      = 1'b1;
                fetch_rd  = (fetch_cnt_reg != pwp_pkg::FETCH_LAST);
                fetch_cap = (fetch_cnt_reg != 3'd0);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: command word processing and fetch sweep
    // ------------------------------------------------------------------
    always_comb
    begin
        logic           stored;
        pwp_pkg::byte_t win_dec;
        pwp_pkg::byte_t digit0;
        pwp_pkg::byte_t digit1;

        stored          = 1'b0;
        win_dec         = win_reg - 8'd1;
        digit0          = '0;
        digit1          = '0;
        fire            = 1'b0;
        fetch_cnt_next  = fetch_cnt_reg;
        ptr_next        = ptr_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        marker_next     = marker_reg;
        sample_cnt_next = sample_cnt_reg;
        rest_cnt_next   = rest_cnt_reg;
        run_next        = run_reg;
        resting_next    = resting_reg;
        win_next        = win_reg;
        cmd0_next       = cmd0_reg;
        cmd1_next       = cmd1_reg;
        cmd_idx_next    = cmd_idx_reg;

        if (accept)
        begin
            case (func)
                pwp_pkg::FUNC_TICK:
                begin
                    // Sample timer acts first
                    if (run_reg)
                    begin
                        if (sample_cnt_reg == sample_period_reg)
                        begin
                            sample_cnt_next = '0;
                            fire            = 1'b1;
                            fetch_cnt_next  = '0;
                            out_next        = hold_reg;
                            // Pointer at or past the end closes the window
                            if (ptr_reg >= pattern_length_reg)
                            begin
                                ptr_next     = '0;
                                run_next     = 1'b0;
                                resting_next = 1'b1;
                                marker_next  = 1'b1;
                                for (int i = 0; i < pwp_pkg::NUM_CHAN; i++)
                                begin
                                    out_next[i] = '0;
                                end
                            end
                        end
                        else
                        begin
                            sample_cnt_next = sample_cnt_reg + 16'd1;
                        end
                    end
                    // Rest timer acts only if it was running at tick start
                    if (resting_reg)
                    begin
                        if (rest_cnt_reg == rest_period_reg)
                        begin
                            resting_next    = 1'b0;
                            rest_cnt_next   = '0;
                            sample_cnt_next = '0;
                            win_next        = win_dec;
                            if (win_dec != 8'd0)
                            begin
                                run_next    = 1'b1;
                                marker_next = 1'b0;
                            end
                        end
                        else
                        begin
                            rest_cnt_next = rest_cnt_reg + 16'd1;
                        end
                    end
                end
                pwp_pkg::FUNC_RX:
                begin
                    // Count up to three bytes; only the first two are stored and read
                    if (cmd_idx_reg != pwp_pkg::CMD_FULL)
                    begin
                        stored = 1'b1;
                        cmd_idx_next = cmd_idx_reg + 2'd1;
                    end
                    if (stored && (cmd_idx_reg == 2'd0))
                    begin
                        cmd0_next = rx_byte;
                    end
                    if (stored && (cmd_idx_reg == 2'd1))
                    begin
                        cmd1_next = rx_byte;
                    end
                    if (rx_byte == pwp_pkg::CMD_END)
                    begin
                        cmd_idx_next    = '0;
                        digit0          = cmd0_next - pwp_pkg::DIGIT_ZERO;
                        digit1          = cmd1_next - pwp_pkg::DIGIT_ZERO;
                        // times ten as shift-add, kept modulo 256
                        win_next        = {digit0[4:0], 3'b000} + {digit0[6:0], 1'b0}
                                          + digit1;
                        sample_cnt_next = '0;
                        rest_cnt_next   = '0;
                        run_next        = 1'b1;
                        marker_next     = 1'b0;
                    end
                end
                pwp_pkg::FUNC_WRITE:
                begin
                    // Low addresses also prime the holding bytes
                    if (write_address <= 16'(pwp_pkg::LAST_CHAN))
                    begin
                        hold_next[write_address[2:0]] = write_data;
                    end
                end
                default:
                begin
                    // unused code: leave state as is
                end
            endcase
        end

        // Fetch sweep: advance the pointer on each read, fill one slot behind
        if (fetch_rd)
        begin
            ptr_next = ptr_reg + 17'd1;
        end
        if (fetch_cap)
        begin
            hold_next[fetch_cnt_reg - 3'd1] = rd_data;
        end
        if (state_reg == pwp_pkg::ST_FETCH)
        begin
            fetch_cnt_next = fetch_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pwp_pkg::ST_IDLE;
            fetch_cnt_reg  <= '0;
            ptr_reg        <= pwp_pkg::PTR_RST;
            for (int i = 0; i < pwp_pkg::NUM_CHAN; i++)
            begin
                hold_reg[i] <= '0;
                out_reg[i]  <= '0;
            end
            marker_reg     <= 1'b1;
            sample_cnt_reg <= '0;
            rest_cnt_reg   <= '0;
            run_reg        <= 1'b0;
            resting_reg    <= 1'b0;
            win_reg        <= '0;
            cmd0_reg       <= '0;
            cmd1_reg       <= '0;
            cmd_idx_reg    <= '0;
            done_reg       <= 1'b0;
            echo_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fetch_cnt_reg  <= fetch_cnt_next;
            ptr_reg        <= ptr_next;
            hold_reg       <= hold_next;
            out_reg        <= out_next;
            marker_reg     <= marker_next;
            sample_cnt_reg <= sample_cnt_next;
            rest_cnt_reg   <= rest_cnt_next;
            run_reg        <= run_next;
            resting_reg    <= resting_next;
            win_reg        <= win_next;
            cmd0_reg       <= cmd0_next;
            cmd1_reg       <= cmd1_next;
            cmd_idx_reg    <= cmd_idx_next;
            done_reg       <= accept;
            if (accept)
            begin
                echo_valid_reg <= (func == pwp_pkg::FUNC_RX);
            end
        end
    end

    // Echo payload: hold the last received byte, zero for other words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_byte_reg <= (func == pwp_pkg::FUNC_RX) ? rx_byte : 8'd0;
        end
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign done         = done_reg;
    assign chan_a       = out_reg[0];
    assign chan_c       = out_reg[1];
    assign chan_f       = out_reg[2];
    assign chan_k       = out_reg[3];
    assign chan_l       = out_reg[4];
    assign rest_marker  = marker_reg;
    assign echo_byte    = echo_byte_reg;
    assign echo_valid   = echo_valid_reg;
    assign playing      = run_reg;
    assign windows_left = win_reg;

endmodule
